[sv/mhts_pkg.sv]
// ---------------------------------------------------------------------------
// mhts_pkg
// Shared widths, request codes and types of the timer heap scheduler.
// ---------------------------------------------------------------------------
package mhts_pkg;

    localparam int REQ_W      = 2;
    localparam int ID_W       = 5;
    localparam int PER_W      = 32;
    localparam int TIME_W     = 48;
    localparam int TIMERS_DEF = 32;
    localparam int MAX_EXP    = 32;
    localparam int NW         = $clog2(MAX_EXP + 1);

    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic cur_lt_a;
        logic cur_lt_b;
        logic a_lt_b;
        logic a_le_now;
    } t_cmp;

endpackage

[sv/mhts_req_if.sv]
// ---------------------------------------------------------------------------
// mhts_req_if
// Request channel: start, stop and tick requests.
// ---------------------------------------------------------------------------
interface mhts_req_if;
    import mhts_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   timer_id;
    logic [PER_W-1:0]  interval_ms;
    logic              periodic;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, req_type, timer_id, interval_ms, periodic, now_ms,
                    input ready);
    modport sink   (input valid, req_type, timer_id, interval_ms, periodic, now_ms,
                    output ready);
endinterface

[sv/mhts_exp_if.sv]
// ---------------------------------------------------------------------------
// mhts_exp_if
// Expiry channel: one beat per expired timer.
// ---------------------------------------------------------------------------
interface mhts_exp_if;
    import mhts_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] expired_timer;
    logic            last;

    modport source (output valid, expired_timer, last, input ready);
    modport sink   (input valid, expired_timer, last, output ready);
endinterface

[sv/mhts_cmp.sv]
// ---------------------------------------------------------------------------
// mhts_cmp
// Shared compare unit and saturating expiry adder of the heap sequencer.
// ---------------------------------------------------------------------------
module mhts_cmp (
    input  logic [mhts_pkg::TIME_W-1:0] i_cur_e,
    input  logic [mhts_pkg::TIME_W-1:0] i_a_e,
    input  logic [mhts_pkg::TIME_W-1:0] i_b_e,
    input  logic [mhts_pkg::TIME_W-1:0] i_now,
    input  logic [mhts_pkg::PER_W-1:0]  i_per,
    output mhts_pkg::t_cmp              o_flags,
    output logic [mhts_pkg::TIME_W-1:0] o_sum
);
    import mhts_pkg::*;

    logic [TIME_W:0] sum;

    assign sum = {1'b0, i_now} + (TIME_W + 1)'(i_per);
    assign o_sum = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    assign o_flags.cur_lt_a = i_cur_e < i_a_e;
    assign o_flags.cur_lt_b = i_cur_e < i_b_e;
    assign o_flags.a_lt_b   = i_a_e < i_b_e;
    assign o_flags.a_le_now = !(i_now < i_a_e);
endmodule

[sv/min_heap_timer_scheduler.sv]
// ---------------------------------------------------------------------------
// min_heap_timer_scheduler
// Timer queue kept as a binary min-heap by expiry time.
//
// i_req carries start, stop and tick requests; a beat is taken only while
// the sequencer is idle. o_exp carries one beat per expired timer, in pop
// order, with last set on the final beat of a tick.
// A start of an idle timer appends the new entry at the end of the heap;
// it then rises one heap level at a time while it is earlier than its parent.
// A stop of a timer that holds the last heap slot only drops that slot;
// otherwise the last entry refills the freed slot and sifts up or down.
// A start of a running timer runs the stop sequence before the insertion.
// A tick gives no beat on an empty heap or when nothing is due; each expiry
// is a removal from the root and, for a periodic timer, a reinsertion.
// The sequencer works through the single heap memory (two read ports, one
// write port) and the one compare unit that every sift step goes through.
// Reset empties the heap and marks every timer idle; no clearing pass.
// When the receiver stalls, the sequencer holds at the next expiry until
// the output register frees up; new requests are taken while the last
// beat of a tick still waits.
// ---------------------------------------------------------------------------
module min_heap_timer_scheduler #(
    parameter int TIMERS = mhts_pkg::TIMERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mhts_req_if.sink     i_req,
    mhts_exp_if.source   o_exp
);
    import mhts_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);
    localparam int XW = IW + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RM_SLOT = 4'd1;
    localparam logic [3:0] S_RM      = 4'd2;
    localparam logic [3:0] S_RM_LAST = 4'd3;
    localparam logic [3:0] S_UP      = 4'd4;
    localparam logic [3:0] S_UP_CMP  = 4'd5;
    localparam logic [3:0] S_DN      = 4'd6;
    localparam logic [3:0] S_DN_CMP  = 4'd7;
    localparam logic [3:0] S_INS     = 4'd8;
    localparam logic [3:0] S_TK_ROOT = 4'd9;
    localparam logic [3:0] S_TK_CHK  = 4'd10;
    localparam logic [3:0] S_TK_REP  = 4'd11;
    localparam logic [3:0] S_TK_END  = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [REQ_W-1:0]  r_op, n_op;
    logic [IW-1:0]     r_tid, n_tid;
    logic [PER_W-1:0]  r_per, n_per;
    logic              r_rep, n_rep;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [TIMERS-1:0] r_live, n_live;
    logic [TIME_W-1:0] r_cur_e, n_cur_e;
    logic [IW-1:0]     r_cur_o, n_cur_o;
    logic [IW-1:0]     r_cur_i, n_cur_i;
    logic              r_down, n_down;
    logic              r_ins, n_ins;
    logic [NW-1:0]     r_n, n_n;
    logic              r_pend_v, n_pend_v;
    logic [IW-1:0]     r_pend, n_pend;
    logic              r_ov, n_ov;
    logic [ID_W-1:0]   r_oid, n_oid;
    logic              r_olast, n_olast;

    logic [TIME_W-1:0] m_e [TIMERS];
    logic [IW-1:0]     m_o [TIMERS];
    logic [IW-1:0]     m_slot [TIMERS];
    logic [PER_W-1:0]  m_per [TIMERS];
    logic              m_rep [TIMERS];

    logic [TIME_W-1:0] rd_a_e, rd_b_e, h_we_e;
    logic [IW-1:0]     rd_a_o, rd_b_o, h_we_o;
    logic [IW-1:0]     rd_slot;
    logic [PER_W-1:0]  rd_per;
    logic              rd_rep;

    logic              h_we, h_re_a, h_re_b, s_we, s_re, p_we, p_re;
    logic [IW-1:0]     h_wa, h_ra, h_rb, s_wa, s_wd, s_ra, p_ra;

    t_cmp              cmp;
    logic [TIME_W-1:0] sum;
    logic [PER_W-1:0]  sum_per;

    logic [6:0]        id_x;
    logic [IW-1:0]     id_i;
    logic              id_ok;
    logic [3:0]        cont;
    logic [IW-1:0]     par;
    logic [XW-1:0]     c_x, c1_x, cnt_x;
    logic              m_is_a;
    logic              out_free;

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            m_e[h_wa] <= h_we_e;
            m_o[h_wa] <= h_we_o;
        end
        if (h_re_a) begin
            rd_a_e <= m_e[h_ra];
            rd_a_o <= m_o[h_ra];
        end
        if (h_re_b) begin
            rd_b_e <= m_e[h_rb];
            rd_b_o <= m_o[h_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            m_slot[s_wa] <= s_wd;
        end
        if (s_re) begin
            rd_slot <= m_slot[s_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            m_per[r_tid] <= r_per;
            m_rep[r_tid] <= r_rep;
        end
        if (p_re) begin
            rd_per <= m_per[p_ra];
            rd_rep <= m_rep[p_ra];
        end
    end

    assign sum_per = (r_state == S_INS) ? r_per : rd_per;

    mhts_cmp u_cmp (
        .i_cur_e (r_cur_e),
        .i_a_e   (rd_a_e),
        .i_b_e   (rd_b_e),
        .i_now   (r_now),
        .i_per   (sum_per),
        .o_flags (cmp),
        .o_sum   (sum)
    );

    assign id_x     = {2'b00, i_req.timer_id};
    assign id_i     = IW'(id_x);
    assign id_ok    = id_x < 7'(TIMERS);
    assign par      = (r_cur_i - 1'b1) >> 1;
    assign c_x      = XW'({r_cur_i, 1'b1});
    assign c1_x     = c_x + 1'b1;
    assign cnt_x    = XW'(r_cnt);
    assign m_is_a   = (c1_x == cnt_x) || cmp.a_lt_b;
    assign out_free = !r_ov || o_exp.ready;

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_exp.valid         = r_ov;
    assign o_exp.expired_timer = r_oid;
    assign o_exp.last          = r_olast;

    always_comb begin
        if (r_ins) begin
            cont = (r_op == REQ_TICK) ? S_TK_ROOT : S_IDLE;
        end else if (r_op == REQ_START) begin
            cont = S_INS;
        end else if (r_op == REQ_STOP) begin
            cont = S_IDLE;
        end else begin
            cont = S_TK_REP;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_tid    = r_tid;
        n_per    = r_per;
        n_rep    = r_rep;
        n_now    = r_now;
        n_cnt    = r_cnt;
        n_live   = r_live;
        n_cur_e  = r_cur_e;
        n_cur_o  = r_cur_o;
        n_cur_i  = r_cur_i;
        n_down   = r_down;
        n_ins    = r_ins;
        n_n      = r_n;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_ov     = r_ov && !o_exp.ready;
        n_oid    = r_oid;
        n_olast  = r_olast;
        h_we     = 1'b0;
        h_wa     = r_cur_i;
        h_we_e   = r_cur_e;
        h_we_o   = r_cur_o;
        h_re_a   = 1'b0;
        h_ra     = par;
        h_re_b   = 1'b0;
        h_rb     = c1_x[IW-1:0];
        s_we     = 1'b0;
        s_wa     = r_cur_o;
        s_wd     = r_cur_i;
        s_re     = 1'b0;
        s_ra     = id_i;
        p_we     = 1'b0;
        p_re     = 1'b0;
        p_ra     = rd_a_o;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op   = i_req.req_type;
                    n_tid  = id_i;
                    n_per  = (i_req.interval_ms == '0) ? PER_W'(1) : i_req.interval_ms;
                    n_rep  = i_req.periodic;
                    n_now  = i_req.now_ms;
                    n_ins  = 1'b0;
                    n_n    = '0;
                    s_re   = 1'b1;
                    case (i_req.req_type)
                        REQ_START: begin
                            if (id_ok) begin
                                n_state = r_live[id_i] ? S_RM_SLOT : S_INS;
                            end
                        end
                        REQ_STOP: begin
                            if (id_ok && r_live[id_i]) begin
                                n_state = S_RM_SLOT;
                            end
                        end
                        REQ_TICK: begin
                            n_state = S_TK_ROOT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RM_SLOT: begin
                n_cur_i = rd_slot;
                n_state = S_RM;
            end
            S_RM: begin
                n_live[r_tid] = 1'b0;
                if (CW'(r_cur_i) == r_cnt - 1'b1) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = cont;
                end else begin
                    h_re_a  = 1'b1;
                    h_ra    = IW'(r_cnt - 1'b1);
                    n_state = S_RM_LAST;
                end
            end
            S_RM_LAST: begin
                n_cur_e = rd_a_e;
                n_cur_o = rd_a_o;
                n_cnt   = r_cnt - 1'b1;
                n_down  = 1'b1;
                n_state = S_UP;
            end
            S_UP: begin
                if (r_cur_i == '0) begin
                    if (r_down) begin
                        n_state = S_DN;
                    end else begin
                        h_we    = 1'b1;
                        s_we    = 1'b1;
                        n_state = cont;
                    end
                end else begin
                    h_re_a  = 1'b1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (cmp.cur_lt_a) begin
                    h_we    = 1'b1;
                    h_we_e  = rd_a_e;
                    h_we_o  = rd_a_o;
                    s_we    = 1'b1;
                    s_wa    = rd_a_o;
                    n_cur_i = par;
                    n_down  = 1'b0;
                    n_state = S_UP;
                end else if (r_down) begin
                    n_state = S_DN;
                end else begin
                    h_we    = 1'b1;
                    s_we    = 1'b1;
                    n_state = cont;
                end
            end
            S_DN: begin
                if (c_x < cnt_x) begin
                    h_re_a  = 1'b1;
                    h_ra    = c_x[IW-1:0];
                    h_re_b  = 1'b1;
                    n_state = S_DN_CMP;
                end else begin
                    h_we    = 1'b1;
                    s_we    = 1'b1;
                    n_state = cont;
                end
            end
            S_DN_CMP: begin
                if (m_is_a ? cmp.cur_lt_a : cmp.cur_lt_b) begin
                    h_we    = 1'b1;
                    s_we    = 1'b1;
                    n_state = cont;
                end else begin
                    h_we    = 1'b1;
                    h_we_e  = m_is_a ? rd_a_e : rd_b_e;
                    h_we_o  = m_is_a ? rd_a_o : rd_b_o;
                    s_we    = 1'b1;
                    s_wa    = m_is_a ? rd_a_o : rd_b_o;
                    n_cur_i = m_is_a ? c_x[IW-1:0] : c1_x[IW-1:0];
                    n_state = S_DN;
                end
            end
            S_INS: begin
                p_we    = 1'b1;
                n_cur_e = sum;
                n_cur_o = r_tid;
                n_cur_i = IW'(r_cnt);
                n_live[r_tid] = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                n_ins   = 1'b1;
                n_down  = 1'b0;
                n_state = S_UP;
            end
            S_TK_ROOT: begin
                n_ins = 1'b0;
                if (r_cnt == '0) begin
                    n_state = S_TK_END;
                end else begin
                    h_re_a  = 1'b1;
                    h_ra    = '0;
                    n_state = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                if (cmp.a_le_now && (r_n < NW'(MAX_EXP))) begin
                    if (!r_pend_v || out_free) begin
                        if (r_pend_v) begin
                            n_ov    = 1'b1;
                            n_oid   = ID_W'(r_pend);
                            n_olast = 1'b0;
                        end
                        n_pend_v = 1'b1;
                        n_pend   = rd_a_o;
                        n_n      = r_n + 1'b1;
                        n_tid    = rd_a_o;
                        p_re     = 1'b1;
                        n_cur_i  = '0;
                        n_state  = S_RM;
                    end
                end else begin
                    n_state = S_TK_END;
                end
            end
            S_TK_REP: begin
                if (rd_rep) begin
                    n_cur_e = sum;
                    n_cur_o = r_tid;
                    n_cur_i = IW'(r_cnt);
                    n_live[r_tid] = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_ins   = 1'b1;
                    n_down  = 1'b0;
                    n_state = S_UP;
                end else begin
                    n_state = S_TK_ROOT;
                end
            end
            S_TK_END: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov     = 1'b1;
                    n_oid    = ID_W'(r_pend);
                    n_olast  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_live   <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            r_n      <= '0;
            r_ins    <= 1'b0;
            r_down   <= 1'b0;
            r_op     <= REQ_START;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_live   <= n_live;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
            r_n      <= n_n;
            r_ins    <= n_ins;
            r_down   <= n_down;
            r_op     <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tid   <= n_tid;
        r_per   <= n_per;
        r_rep   <= n_rep;
        r_now   <= n_now;
        r_cur_e <= n_cur_e;
        r_cur_o <= n_cur_o;
        r_cur_i <= n_cur_i;
        r_pend  <= n_pend;
        r_oid   <= n_oid;
        r_olast <= n_olast;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TIMERS))
        else $error("heap count beyond capacity");

    a_live_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_live) == int'(r_cnt)))
        else $error("live timers disagree with heap count");

    a_exp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_EXP))
        else $error("too many expiries in one tick");

    a_heap_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_we |-> (r_state == S_UP || r_state == S_UP_CMP
                  || r_state == S_DN || r_state == S_DN_CMP))
        else $error("heap write outside a sift step");

endmodule

[tb/min_heap_timer_scheduler_tb.sv]
// ---------------------------------------------------------------------------
// min_heap_timer_scheduler_tb
// Drives start, stop and tick requests into the timer heap and checks each
// expiry beat against an in-bench heap predictor. A directed table comes
// first, then random traffic with random idling on both channels.
// ---------------------------------------------------------------------------
module min_heap_timer_scheduler_tb;
    import mhts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT        = TIMERS_DEF;
    localparam int IDLE_LIM  = 20000;
    localparam int DRAIN_CYC = 200;

    localparam logic [REQ_W-1:0] REQ_BAD = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [ID_W-1:0]   id;
        logic [PER_W-1:0]  ivl;
        logic              rep;
        logic [TIME_W-1:0] now;
        logic              has_exp;
        logic [ID_W-1:0]   exp_id;
        logic              exp_last;
    } t_row;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            last;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    mhts_req_if req_if ();
    mhts_exp_if exp_if ();

    min_heap_timer_scheduler #(.TIMERS(NT)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_exp  (exp_if.source)
    );

    logic [TIME_W-1:0] hp_exp [NT];
    logic [ID_W-1:0]   hp_own [NT];
    int                hp_cnt;
    int                slot_of [NT];
    bit                live [NT];
    logic [PER_W-1:0]  period [NT];
    bit                repeats [NT];

    t_beat pending_expiries [$];
    int    errors;
    int    idle_cycles;
    bit    no_idle;
    bit    done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] now, logic [PER_W-1:0] p);
        logic [TIME_W:0] s;
        s = {1'b0, now} + (TIME_W + 1)'(p);
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic void hswap(int a, int b);
        logic [TIME_W-1:0] e;
        logic [ID_W-1:0]   o;
        e = hp_exp[a]; o = hp_own[a];
        hp_exp[a] = hp_exp[b]; hp_own[a] = hp_own[b];
        hp_exp[b] = e; hp_own[b] = o;
        slot_of[hp_own[a]] = a;
        slot_of[hp_own[b]] = b;
    endfunction

    function automatic void hup(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(hp_exp[i] < hp_exp[p])) break;
            hswap(i, p);
            i = p;
        end
    endfunction

    function automatic void hdown(int i);
        int c;
        int m;
        c = 2 * i + 1;
        while (c < hp_cnt) begin
            m = (c + 1 == hp_cnt || hp_exp[c] < hp_exp[c+1]) ? c : c + 1;
            if (hp_exp[i] < hp_exp[m]) break;
            hswap(i, m);
            i = m;
            c = 2 * i + 1;
        end
    endfunction

    function automatic void hinsert(int id, logic [TIME_W-1:0] e);
        int i;
        i = hp_cnt;
        if (i >= NT) return;
        hp_exp[i] = e; hp_own[i] = ID_W'(id);
        slot_of[id] = i; live[id] = 1;
        hp_cnt = i + 1;
        hup(i);
    endfunction

    function automatic void hremove(int id);
        int i;
        i = slot_of[id];
        live[id] = 0;
        if (hp_cnt == 0 || i >= hp_cnt) return;
        if (i == hp_cnt - 1) begin
            hp_cnt--;
            return;
        end
        hswap(i, hp_cnt - 1);
        hp_cnt--;
        if (i > 0 && hp_exp[i] < hp_exp[(i-1)/2]) hup(i);
        else hdown(i);
    endfunction

    function automatic void predict_expiries(t_row r);
        int n;
        int t;
        t_beat b;
        n = 0;
        if (r.kind == REQ_START) begin
            if (live[r.id]) hremove(r.id);
            period[r.id]  = (r.ivl == '0) ? PER_W'(1) : r.ivl;
            repeats[r.id] = r.rep;
            hinsert(r.id, sat_add(r.now, period[r.id]));
        end else if (r.kind == REQ_STOP) begin
            if (live[r.id]) hremove(r.id);
        end else if (r.kind == REQ_TICK) begin
            while (hp_cnt > 0 && hp_exp[0] <= r.now && n < MAX_EXP) begin
                t = hp_own[0];
                hremove(t);
                if (repeats[t]) hinsert(t, sat_add(r.now, period[t]));
                b.id = ID_W'(t);
                b.last = 0;
                pending_expiries = {pending_expiries, b};
                n++;
            end
            if (n > 0) pending_expiries[$].last = 1;
        end
    endfunction

    task automatic send_req(t_row r);
        int gap;
        gap = 0;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 20 && gap < 6) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
            gap++;
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= r.kind;
        req_if.timer_id    <= r.id;
        req_if.interval_ms <= r.ivl;
        req_if.periodic    <= r.rep;
        req_if.now_ms      <= r.now;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_expiries(r);
        if (r.has_exp && pending_expiries.size() == 0) begin
            errors++;
            $display("%0t: table row: expected %0d/%0b, actual no expiry", $time,
                     r.exp_id, r.exp_last);
        end else if (r.has_exp && (pending_expiries[0].id != r.exp_id ||
                pending_expiries[0].last != r.exp_last)) begin
            errors++;
            $display("%0t: table row: expected %0d/%0b, actual %0d/%0b", $time,
                     r.exp_id, r.exp_last, pending_expiries[0].id, pending_expiries[0].last);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_expiries.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_row mk(logic [REQ_W-1:0] k, int id, logic [PER_W-1:0] ivl,
                                bit rep, logic [TIME_W-1:0] now);
        t_row r;
        r = '0;
        r.kind = k; r.id = ID_W'(id); r.ivl = ivl; r.rep = rep; r.now = now;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && exp_if.valid && exp_if.ready) begin
            if (pending_expiries.size() == 0) begin
                errors++;
                $display("%0t: unexpected expiry: expected none, actual id %0d last %0b",
                         $time, exp_if.expired_timer, exp_if.last);
            end else begin
                e = pending_expiries.pop_front();
                if (exp_if.expired_timer !== e.id) begin
                    errors++;
                    $display("%0t: expired_timer mismatch: expected %0d, actual %0d",
                             $time, e.id, exp_if.expired_timer);
                end
                if (exp_if.last !== e.last) begin
                    errors++;
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, e.last, exp_if.last);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        exp_if.ready <= no_idle || ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (exp_if.valid && exp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (!done && idle_cycles >= IDLE_LIM) begin
            $display("min_heap_timer_scheduler test failed");
            $finish;
        end
    end

    initial begin
        t_row tbl [$];
        t_row r;
        logic [TIME_W-1:0] clk_now;
        int sel;
        int k;
        errors = 0; idle_cycles = 0; no_idle = 0; done = 0;
        hp_cnt = 0;
        for (int i = 0; i < NT; i++) begin
            live[i] = 0; slot_of[i] = 0; period[i] = '0; repeats[i] = 0;
            hp_exp[i] = '0; hp_own[i] = '0;
        end
        i_rst_n = 1'b0;
        req_if.valid = 1'b0; req_if.req_type = REQ_START; req_if.timer_id = '0;
        req_if.interval_ms = '0; req_if.periodic = 1'b0; req_if.now_ms = '0;
        exp_if.ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty tick, zero interval, extremes, saturation, stop, ignored type
        tbl = {tbl, mk(REQ_TICK, 0, 0, 0, TIME_MAX)};
        tbl = {tbl, mk(REQ_STOP, 7, 0, 0, 0)};
        tbl = {tbl, mk(REQ_START, 0, 0, 0, 0)};
        r = mk(REQ_TICK, 0, 0, 0, 1); r.has_exp = 1; r.exp_id = 0; r.exp_last = 1;
        tbl = {tbl, r};
        tbl = {tbl, mk(REQ_START, 31, '1, 1, TIME_MAX)};
        tbl = {tbl, mk(REQ_START, 5, '1, 0, 0)};
        tbl = {tbl, mk(REQ_START, 6, 10, 1, 100)};
        tbl = {tbl, mk(REQ_START, 6, 20, 0, 100)};
        tbl = {tbl, mk(REQ_STOP, 5, 0, 0, 0)};
        tbl = {tbl, mk(REQ_STOP, 5, 0, 0, 0)};
        tbl = {tbl, mk(REQ_BAD, 31, '1, 1, TIME_MAX)};
        tbl = {tbl, mk(REQ_TICK, 0, 0, 0, 119)};
        r = mk(REQ_TICK, 0, 0, 0, 120); r.has_exp = 1; r.exp_id = 6; r.exp_last = 1;
        tbl = {tbl, r};
        for (int i = 0; i < NT; i++) tbl = {tbl, mk(REQ_START, i, 1 + (i % 3), 1, 0)};
        tbl = {tbl, mk(REQ_TICK, 0, 0, 0, TIME_MAX - 1)};
        tbl = {tbl, mk(REQ_TICK, 0, 0, 0, TIME_MAX)};
        foreach (tbl[i]) send_req(tbl[i]);
        wait_drained();
        for (int i = 0; i < NT; i++) send_req(mk(REQ_STOP, i, 0, 0, 0));

        clk_now = 1000;
        for (k = 0; k < 500; k++) begin
            no_idle = (k >= 200 && k < 280);
            if (k == 350) wait_drained();
            sel = $urandom_range(99);
            if (sel < 45) begin
                r = mk(REQ_START, $urandom_range(NT - 1),
                       ($urandom_range(9) == 0) ? $urandom : $urandom_range(60),
                       1'($urandom_range(1)), clk_now);
                if ($urandom_range(19) == 0) r.now = TIME_W'({$urandom, $urandom});
            end else if (sel < 60) begin
                r = mk(REQ_STOP, $urandom_range(NT - 1), $urandom,
                       1'($urandom_range(1)), clk_now);
            end else if (sel < 97) begin
                clk_now = clk_now + $urandom_range(40);
                r = mk(REQ_TICK, $urandom, $urandom, 1'($urandom_range(1)), clk_now);
            end else begin
                r = mk(REQ_BAD, $urandom, $urandom, 1'($urandom_range(1)),
                       TIME_W'({$urandom, $urandom}));
            end
            send_req(r);
        end
        wait_drained();
        repeat (DRAIN_CYC) @(negedge i_clk);
        done = 1;
        if (errors == 0) begin
            $display("min_heap_timer_scheduler test passed");
        end else begin
            $display("min_heap_timer_scheduler test failed");
        end
        $finish;
    end
endmodule

[sim.f]
sv/mhts_pkg.sv
sv/mhts_req_if.sv
sv/mhts_exp_if.sv
sv/mhts_cmp.sv
sv/min_heap_timer_scheduler.sv
tb/min_heap_timer_scheduler_tb.sv
